// ===== rtl/bsd_pkg.sv =====
// Shared types, command codes and 8b/10b decode tables for the deserializer.
package bsd_pkg;

    localparam int SYM_W  = 10;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 4;
    localparam int ADDR_W = 4;

    localparam logic [CNT_W-1:0] SYMBOL_BITS = 4'd10;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_RESYNC = 2'd1,
        CMD_RESET  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_COMMA_MINUS = 2'd0;
    localparam logic [1:0] REG_COMMA_PLUS  = 2'd1;
    localparam logic [1:0] REG_COMMA_CODE  = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0]  comma_minus;
        logic [SYM_W-1:0]  comma_plus;
        logic [BYTE_W-1:0] comma_code;
    } cfg_t;

    typedef struct packed {
        logic [SYM_W-1:0]  raw_symbol;
        logic [BYTE_W-1:0] decoded_byte;
        logic              symbol_valid;
        logic              is_control;
        logic              is_comma;
    } result_t;

    // Index abcdei; bit 5 flags a legal sub-block, bits 4..0 hold EDCBA.
    localparam logic [5:0] DEC6_LUT [64] = '{
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h37, 6'h28, 6'h27,
        6'h00, 6'h3B, 6'h24, 6'h34, 6'h38, 6'h2C, 6'h3C, 6'h00,
        6'h00, 6'h3D, 6'h22, 6'h32, 6'h3F, 6'h2A, 6'h3A, 6'h2F,
        6'h20, 6'h26, 6'h36, 6'h30, 6'h2E, 6'h21, 6'h3E, 6'h00,
        6'h00, 6'h3E, 6'h21, 6'h31, 6'h30, 6'h29, 6'h39, 6'h20,
        6'h2F, 6'h25, 6'h35, 6'h3F, 6'h2D, 6'h22, 6'h3D, 6'h00,
        6'h00, 6'h23, 6'h33, 6'h38, 6'h2B, 6'h24, 6'h3B, 6'h00,
        6'h27, 6'h28, 6'h37, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00
    };

    // Index fghj; bit 3 flags a legal sub-block, bits 2..0 hold HGF.
    localparam logic [3:0] DEC4_LUT [16] = '{
        4'h0, 4'hF, 4'hC, 4'hB, 4'h8, 4'hA, 4'hE, 4'hF,
        4'hF, 4'h9, 4'hD, 4'h8, 4'hB, 4'hC, 4'hF, 4'h0
    };

endpackage

// ===== rtl/bsd_decode.sv =====
// Table decoder that maps one 10-bit symbol to its data byte.
module bsd_decode
    import bsd_pkg::*;
(
    input  logic [SYM_W-1:0]  symbol,
    output logic [BYTE_W-1:0] data_byte,
    output logic              data_valid
);

    logic [5:0] hi;
    logic [3:0] lo;

    assign hi = DEC6_LUT[symbol[9:4]];
    assign lo = DEC4_LUT[symbol[3:0]];

    always_comb begin
        data_valid = hi[5] & lo[3];
        if (data_valid) begin
            data_byte = {lo[2:0], hi[4:0]};
        end else begin
            data_byte = '0;
        end
    end

endmodule

// ===== rtl/bsd_core.sv =====
// Bit window, comma alignment, symbol phase counter and result register.
module bsd_core
    import bsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_cmd,
    input  logic       in_bit,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    logic [SYM_W-1:0] window_reg, window_next;
    logic             aligned_reg, aligned_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             valid_reg, valid_next;
    result_t          result_reg, result_next;

    logic [SYM_W-1:0]  shifted;
    logic [CNT_W-1:0]  count_inc;
    logic [BYTE_W-1:0] dec_byte;
    logic              dec_valid;
    logic              accept;
    logic              emit;

    bsd_decode u_decode (
        .symbol     (shifted),
        .data_byte  (dec_byte),
        .data_valid (dec_valid)
    );

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign shifted   = {window_reg[SYM_W-2:0], in_bit};
    assign count_inc = count_reg + 1'b1;
    assign out_valid = valid_reg;
    assign out_data  = result_reg;

    always_comb begin
        window_next  = window_reg;
        aligned_next = aligned_reg;
        count_next   = count_reg;
        result_next  = result_reg;
        emit         = 1'b0;
        if (accept) begin
            case (cmd_t'(in_cmd))
                CMD_RESYNC: begin
                    window_next  = '0;
                    count_next   = '0;
                    aligned_next = 1'b1;
                end
                CMD_RESET: begin
                    window_next  = '0;
                    count_next   = '0;
                    aligned_next = 1'b0;
                end
                CMD_PUSH: begin
                    window_next = shifted;
                    if (shifted == cfg.comma_minus || shifted == cfg.comma_plus) begin
                        aligned_next = 1'b1;
                        count_next   = '0;
                        emit         = 1'b1;
                        result_next  = '{shifted, cfg.comma_code, 1'b1, 1'b1, 1'b1};
                    end else if (aligned_reg) begin
                        if (count_inc >= SYMBOL_BITS) begin
                            count_next  = '0;
                            emit        = 1'b1;
                            result_next = '{shifted, dec_byte, dec_valid, 1'b0, 1'b0};
                        end else begin
                            count_next = count_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (emit) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            aligned_reg <= 1'b0;
            count_reg   <= '0;
            valid_reg   <= 1'b0;
        end else begin
            window_reg  <= window_next;
            aligned_reg <= aligned_next;
            count_reg   <= count_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

endmodule

// ===== rtl/bit_serial_8b10b_deserializer.sv =====
// Top level of the bit-serial 8b/10b deserializer with configuration registers.
//
// The input channel (s_valid, s_ready, s_cmd, s_line_bit) carries one command per
// transfer: push one line bit, resync the symbol phase, or clear alignment.
// The result channel (m_valid, m_ready, m_*) carries one decoded symbol per
// transfer. A pushed bit that completes a comma gives a comma result at once;
// once aligned, every tenth pushed bit gives a data symbol result.
// Throughput is one input transfer per cycle while the result channel does not
// stall, set by the single pass through the window update and decode tables. A
// result appears on the result ports in the cycle after the input transfer
// that causes it. The output register lets a new input transfer be taken in
// the same cycle that a waiting result is taken. While a result waits and
// m_ready is low, s_ready is low. Synchronous reset clears the window,
// alignment, phase counter and result valid, and returns the comma registers
// to their defaults. The APB port (registers at byte addresses 0, 4 and 8) is
// to be written only while idle; the block itself does not enforce this.
module bit_serial_8b10b_deserializer
    import bsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic              s_line_bit,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SYM_W-1:0]  m_raw_symbol,
    output logic [BYTE_W-1:0] m_decoded_byte,
    output logic              m_symbol_valid,
    output logic              m_is_control,
    output logic              m_is_comma
);

    cfg_t    cfg_reg, cfg_next;
    result_t result;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_COMMA_MINUS: cfg_next.comma_minus = pwdata[SYM_W-1:0];
                REG_COMMA_PLUS:  cfg_next.comma_plus  = pwdata[SYM_W-1:0];
                REG_COMMA_CODE:  cfg_next.comma_code  = pwdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COMMA_MINUS: prdata = {22'd0, cfg_reg.comma_minus};
            REG_COMMA_PLUS:  prdata = {22'd0, cfg_reg.comma_plus};
            REG_COMMA_CODE:  prdata = {24'd0, cfg_reg.comma_code};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{10'h0F8, 10'h307, 8'hFC};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bsd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (s_cmd),
        .in_bit    (s_line_bit),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (result)
    );

    assign m_raw_symbol   = result.raw_symbol;
    assign m_decoded_byte = result.decoded_byte;
    assign m_symbol_valid = result.symbol_valid;
    assign m_is_control   = result.is_control;
    assign m_is_comma     = result.is_comma;

endmodule
